// ===== sv/swhr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swhr_pkg: shared types and constants of the single-wire sensor reader
// Item structs, counter widths, frame layout and register indexes.
// ----------------------------------------------------------------------------
package swhr_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int FRAME_BITS  = 40;
  localparam int CFG_WIDTH   = 16;
  localparam int WORD_WIDTH  = 16;
  localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
  localparam int BIT_IDX_W   = $clog2(FRAME_BITS + 1);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = '1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_ONE  = COUNT_WIDTH'(1);
  localparam logic [WORD_WIDTH-1:0]  ERR_WORD   = WORD_WIDTH'(99);
  localparam logic [CFG_WIDTH-1:0]   START_LOW_RESET = CFG_WIDTH'(19000);
  localparam logic [CFG_WIDTH-1:0]   TIMEOUT_RESET   = CFG_WIDTH'(500);

  // Register indexes of the configuration port
  localparam logic CFG_START_LOW_TICKS  = 1'b0;
  localparam logic CFG_RESPONSE_TIMEOUT = 1'b1;

  // Opcodes of an input item
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef struct packed {
    logic opcode;
    logic line_level;
  } swhr_in_t;

  typedef struct packed {
    logic                  drive_low;
    logic                  busy_res;
    logic                  done_res;
    logic                  read_error;
    logic [WORD_WIDTH-1:0] humidity_raw;
    logic [WORD_WIDTH-1:0] temperature_raw;
  } swhr_out_t;

endpackage

// ===== sv/single_wire_humidity_sensor_reader.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_reader: top level of the sensor reader
// Steps the read sequence once per timer tick or start item.
// ----------------------------------------------------------------------------
// Each input item is one timer tick with the sampled data line, or a start
// command. Every item gives exactly one result item: line drive, busy, a done
// pulse, the error flag and the held humidity and temperature words. The block
// takes one item per clock cycle; the result of an item shows in the result
// register on the next cycle. in_ready_o is high whenever the result register
// is empty or its item is taken in the same cycle, so a stalled consumer stops
// intake only while the result register is full. Configuration writes are
// taken in any cycle, with no wait.
module single_wire_humidity_sensor_reader (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  swhr_pkg::swhr_in_t             in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output swhr_pkg::swhr_out_t            out_item_o,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [swhr_pkg::CFG_WIDTH-1:0] cfg_data_i
);
  import swhr_pkg::*;

  logic      accept;
  logic      free;
  swhr_out_t result;

  // Advance the sequencer only on an accepted item
  assign in_ready_o = free;
  assign accept     = in_valid_i && free;

  swhr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .result_o    (result)
  );

  // Hold the result item apart from the input side
  swhr_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .result_i    (result),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== sv/swhr_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swhr_core: read sequencer of the single-wire sensor reader
// Holds phase, counters and result words; steps once per accepted item.
// ----------------------------------------------------------------------------
module swhr_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  swhr_pkg::swhr_in_t             item_i,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [swhr_pkg::CFG_WIDTH-1:0] cfg_data_i,
  output swhr_pkg::swhr_out_t            result_o
);
  import swhr_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_START, PH_RESP_HIGH, PH_RESP_LOW, PH_RESP_END, PH_BIT_LOW, PH_BIT_HIGH
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] tick_q, tick_d;
  logic [COUNT_WIDTH-1:0] calib_q, calib_d;
  logic [BIT_IDX_W-1:0]   bit_idx_q, bit_idx_d;
  logic [FRAME_BITS-1:0]  shift_q, shift_d;
  logic [WORD_WIDTH-1:0]  hum_q, hum_d;
  logic [WORD_WIDTH-1:0]  temp_q, temp_d;
  logic                   err_q, err_d;
  logic                   done;
  logic [CFG_WIDTH-1:0]   start_low_q;
  logic [CFG_WIDTH-1:0]   timeout_q;

  logic [COUNT_WIDTH-1:0] tick_sat;
  logic                   resp_expired;
  logic                   bit_one;
  logic [FRAME_BITS-1:0]  shift_next;
  logic [BIT_IDX_W-1:0]   bit_idx_next;

  // Saturating increment and the compares against the 16-bit registers
  assign tick_sat     = (tick_q != COUNT_MAX) ? tick_q + COUNT_ONE : tick_q;
  assign resp_expired = (CMP_WIDTH'(tick_q) >= CMP_WIDTH'(timeout_q)) ||
                        (tick_q == COUNT_MAX);
  assign bit_one      = tick_q > (calib_q >> 1);
  assign shift_next   = {shift_q[FRAME_BITS-2:0], bit_one};
  assign bit_idx_next = bit_idx_q + BIT_IDX_W'(1);

  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    calib_d   = calib_q;
    bit_idx_d = bit_idx_q;
    shift_d   = shift_q;
    hum_d     = hum_q;
    temp_d    = temp_q;
    err_d     = err_q;
    done      = 1'b0;
    if (item_i.opcode == OP_START) begin
      phase_d   = PH_START;
      tick_d    = '0;
      bit_idx_d = '0;
      shift_d   = '0;
    end else begin
      case (phase_q)
        PH_START: begin
          tick_d = tick_sat;
          if (CMP_WIDTH'(tick_sat) >= CMP_WIDTH'(start_low_q)) begin
            phase_d = PH_RESP_HIGH;
            tick_d  = '0;
          end
        end
        PH_RESP_HIGH, PH_RESP_LOW: begin
          if (item_i.line_level == (phase_q == PH_RESP_HIGH)) begin
            if (resp_expired) begin
              hum_d   = ERR_WORD;
              temp_d  = ERR_WORD;
              err_d   = 1'b1;
              phase_d = PH_IDLE;
              done    = 1'b1;
            end else begin
              tick_d = tick_q + COUNT_ONE;
            end
          end else if (phase_q == PH_RESP_HIGH) begin
            phase_d = PH_RESP_LOW;
          end else begin
            calib_d = tick_q;
            tick_d  = '0;
            phase_d = PH_RESP_END;
          end
        end
        PH_RESP_END: begin
          if (!item_i.line_level) phase_d = PH_BIT_LOW;
        end
        PH_BIT_LOW: begin
          if (item_i.line_level) begin
            tick_d  = '0;
            phase_d = PH_BIT_HIGH;
          end
        end
        PH_BIT_HIGH: begin
          if (item_i.line_level) begin
            tick_d = tick_sat;
          end else begin
            shift_d   = shift_next;
            bit_idx_d = bit_idx_next;
            if (bit_idx_next >= BIT_IDX_W'(FRAME_BITS)) begin
              hum_d     = shift_next[FRAME_BITS-1 -: WORD_WIDTH];
              temp_d    = shift_next[FRAME_BITS-WORD_WIDTH-1 -: WORD_WIDTH];
              err_d     = 1'b0;
              bit_idx_d = '0;
              phase_d   = PH_IDLE;
              done      = 1'b1;
            end else begin
              phase_d = PH_BIT_LOW;
            end
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  assign result_o.drive_low       = (phase_d == PH_START);
  assign result_o.busy_res        = (phase_d != PH_IDLE);
  assign result_o.done_res        = done;
  assign result_o.read_error      = err_d;
  assign result_o.humidity_raw    = hum_d;
  assign result_o.temperature_raw = temp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      calib_q     <= '0;
      bit_idx_q   <= '0;
      shift_q     <= '0;
      hum_q       <= ERR_WORD;
      temp_q      <= ERR_WORD;
      err_q       <= 1'b0;
      start_low_q <= START_LOW_RESET;
      timeout_q   <= TIMEOUT_RESET;
    end else begin
      if (accept_i) begin
        phase_q   <= phase_d;
        tick_q    <= tick_d;
        calib_q   <= calib_d;
        bit_idx_q <= bit_idx_d;
        shift_q   <= shift_d;
        hum_q     <= hum_d;
        temp_q    <= temp_d;
        err_q     <= err_d;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_START_LOW_TICKS:  start_low_q <= cfg_data_i;
          CFG_RESPONSE_TIMEOUT: timeout_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== sv/swhr_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swhr_out_reg: result register of the single-wire sensor reader
// Holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module swhr_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  swhr_pkg::swhr_out_t result_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output swhr_pkg::swhr_out_t out_item_o
);
  import swhr_pkg::*;

  logic      valid_q;
  swhr_out_t data_q;

  // Take a new item when empty or when the held one leaves this cycle
  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) data_q <= result_i;
  end

endmodule

// ===== sv/swhr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swhr_checker: port-level checks of the single-wire sensor reader
// Watches the top level ports and flags broken result behavior.
// ----------------------------------------------------------------------------
module swhr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input swhr_pkg::swhr_in_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input swhr_pkg::swhr_out_t out_item_o
);
  import swhr_pkg::*;

  // Hold a stalled result item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  // Accept input whenever the result register is empty
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // An accepted start item shows the line pulled low next cycle
  a_start_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.opcode == OP_START)
      |=> out_valid_o && out_item_o.drive_low && out_item_o.busy_res)
    else $error("start item did not drive the line low");

  // A finished read leaves the block idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.done_res |-> !out_item_o.busy_res)
    else $error("done pulse while still busy");

endmodule

bind single_wire_humidity_sensor_reader swhr_checker u_swhr_checker (.*);
